[rtl/totp_pkg.sv]
// shared types, constants and functions for the one-time code generator
package totp_pkg;

   localparam int MaxKeyBytes = 32;
   localparam int KeyLenWidth = 6;
   localparam int TimeWidth   = 63;
   localparam int OtpWidth    = 27;
   localparam int SecWidth    = 9;

   localparam logic [3:0] DefaultDigits = 4'd6;
   localparam logic [8:0] DefaultPeriod = 9'd30;
   localparam logic [8:0] MinPeriod     = 9'd10;
   localparam logic [8:0] MaxPeriod     = 9'd300;

   // register indexes of the configuration channel
   localparam logic [2:0] RegKey0      = 3'd0;
   localparam logic [2:0] RegKey1      = 3'd1;
   localparam logic [2:0] RegKey2      = 3'd2;
   localparam logic [2:0] RegKey3      = 3'd3;
   localparam logic [2:0] RegKeyLength = 3'd4;
   localparam logic [2:0] RegDigits    = 3'd5;
   localparam logic [2:0] RegPeriod    = 3'd6;

   // sha-1 initial chaining value
   localparam logic [159:0] ShaInit =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   // sequencer states of the top level
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_IPAD,
      ST_INNER,
      ST_OPAD,
      ST_OUTER1,
      ST_OUTER2,
      ST_TRUNC,
      ST_MOD,
      ST_DONE
   } state_type;

   // command and status between sequencer and the sha-1 round unit
   typedef struct packed {
      logic         start;
      logic         init;
   } sha_cmd_type;

   typedef struct packed {
      logic         busy;
      logic         done;
   } sha_sts_type;

   // sha-1 round constant for round group
   function automatic logic [31:0] sha_k(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20)      k = 32'h5A827999;
      else if (rnd < 7'd40) k = 32'h6ED9EBA1;
      else if (rnd < 7'd60) k = 32'h8F1BBCDC;
      else                  k = 32'hCA62C1D6;
      return k;
   endfunction

   // ten to the power of the digit count
   function automatic logic [26:0] pow10(input logic [3:0] digits);
      logic [26:0] p;
      case (digits)
         4'd7:    p = 27'd10000000;
         4'd8:    p = 27'd100000000 - 27'd0;
         default: p = 27'd1000000;
      endcase
      return p;
   endfunction

endpackage

[rtl/totp_code_generator_core.sv]
// top level of the one-time code generator: sequencer, registers and result stage
// Each beat on req carries a Unix time and produces one beat on rsp with the
// truncated HMAC-SHA1 code and the seconds left in the window. The steps between
// the req beat and rsp_tvalid are the bit-serial time/period division, four sha-1
// compressions on the single round unit (inner key block, inner message block,
// outer key block, outer digest block), the truncation, and the code reduction on
// the same divider. req_tready is low while an item is in work, and stays low
// until the result beat has been taken.
module totp_code_generator_core (
   input  logic        clock,
   input  logic        reset,
   // fields: unix_time[62:0]
   input  logic [63:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fields: otp_value[26:0], seconds_left[35:27]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        csr_valid,
   output logic        csr_ready
);

   totp_pkg::state_type state_ff, state_in;

   logic [63:0]  key_ff [4];
   logic [5:0]   klen_ff;
   logic [3:0]   digits_ff;
   logic [8:0]   period_ff;

   logic [62:0]  time_ff, time_in;
   logic [63:0]  ctr_ff, ctr_in;
   logic [8:0]   left_ff, left_in;
   logic [159:0] ih_ff, ih_in;
   logic [31:0]  bin_ff, bin_in;
   logic [26:0]  otp_ff, otp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   totp_pkg::sha_cmd_type sha_cmd;
   totp_pkg::sha_sts_type sha_sts;
   logic [511:0] blk;
   logic [159:0] digest;

   logic         div_start, div_done;
   logic [62:0]  div_q, div_a;
   logic [26:0]  div_r, div_d;

   logic [255:0] key_flat;
   logic [511:0] key_pad;
   logic [3:0]   off;
   logic [159:0] sh;

   // configuration writes with range replacement
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         klen_ff   <= 6'd20;
         digits_ff <= totp_pkg::DefaultDigits;
         period_ff <= totp_pkg::DefaultPeriod;
      end else if (csr_valid) begin
         unique case (csr_index)
            totp_pkg::RegKey0:      key_ff[0] <= csr_data;
            totp_pkg::RegKey1:      key_ff[1] <= csr_data;
            totp_pkg::RegKey2:      key_ff[2] <= csr_data;
            totp_pkg::RegKey3:      key_ff[3] <= csr_data;
            totp_pkg::RegKeyLength: klen_ff <= csr_data[5:0];
            totp_pkg::RegDigits:
               digits_ff <= (csr_data[3:0] < 4'd6 || csr_data[3:0] > 4'd8) ?
                            totp_pkg::DefaultDigits : csr_data[3:0];
            totp_pkg::RegPeriod:
               period_ff <= (csr_data[8:0] < totp_pkg::MinPeriod ||
                             csr_data[8:0] > totp_pkg::MaxPeriod) ?
                            totp_pkg::DefaultPeriod : csr_data[8:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // key masked to its length, byte 0 in the top bits of a 64-byte block
   always_comb begin
      key_flat = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
      for (int i = 0; i < totp_pkg::MaxKeyBytes; i++) begin
         if (6'(i) >= klen_ff) key_flat[255 - 8*i -: 8] = 8'h00;
      end
      key_pad = {key_flat, 256'd0};
   end

   // block assembly for each compression
   always_comb begin
      unique case (state_ff)
         totp_pkg::ST_IPAD:   blk = key_pad ^ {64{8'h36}};
         totp_pkg::ST_OPAD:   blk = key_pad ^ {64{8'h5C}};
         totp_pkg::ST_INNER:  blk = {ctr_ff, 8'h80, 376'd0, 64'd576};
         totp_pkg::ST_OUTER2: blk = {ih_ff, 8'h80, 280'd0, 64'd672};
         default:             blk = key_pad ^ {64{8'h5C}};
      endcase
   end

   // dynamic truncation: four bytes from the offset given by the last nibble
   always_comb begin
      off = digest[3:0];
      sh  = digest << {off, 3'b000};
   end

   // divider shared by the window division and the code reduction
   assign div_a = (state_ff == totp_pkg::ST_DIV) ? time_ff : {31'd0, bin_ff};
   assign div_d = (state_ff == totp_pkg::ST_DIV) ? {18'd0, period_ff} :
                  totp_pkg::pow10(digits_ff);

   totp_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   totp_sha1_core u_sha (
      .clock      (clock),
      .reset      (reset),
      .cmd        (sha_cmd),
      .block_data (blk),
      .sts        (sha_sts),
      .digest     (digest)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      ctr_in       = ctr_ff;
      left_in      = left_ff;
      ih_in        = ih_ff;
      bin_in       = bin_ff;
      otp_in       = otp_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;
      sha_cmd      = '0;
      unique case (state_ff)
         totp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               time_in  = req_tdata[62:0];
               state_in = totp_pkg::ST_DIV;
            end
         end
         totp_pkg::ST_DIV: begin
            div_start = 1'b1;
            if (div_done) begin
               ctr_in   = {1'b0, div_q};
               left_in  = period_ff - div_r[8:0];
               state_in = totp_pkg::ST_IPAD;
            end
         end
         totp_pkg::ST_IPAD: begin
            sha_cmd.start = 1'b1;
            sha_cmd.init  = 1'b1;
            if (sha_sts.done) state_in = totp_pkg::ST_INNER;
         end
         totp_pkg::ST_INNER: begin
            sha_cmd.start = 1'b1;
            if (sha_sts.done) begin
               ih_in    = digest;
               state_in = totp_pkg::ST_OPAD;
            end
         end
         totp_pkg::ST_OPAD: begin
            sha_cmd.start = 1'b1;
            sha_cmd.init  = 1'b1;
            if (sha_sts.done) state_in = totp_pkg::ST_OUTER2;
         end
         totp_pkg::ST_OUTER2: begin
            sha_cmd.start = 1'b1;
            if (sha_sts.done) state_in = totp_pkg::ST_TRUNC;
         end
         totp_pkg::ST_TRUNC: begin
            bin_in   = {1'b0, sh[158:128]};
            state_in = totp_pkg::ST_MOD;
         end
         totp_pkg::ST_MOD: begin
            div_start = 1'b1;
            if (div_done) begin
               otp_in       = div_r;
               rsp_valid_in = 1'b1;
               state_in     = totp_pkg::ST_DONE;
            end
         end
         totp_pkg::ST_DONE: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = totp_pkg::ST_IDLE;
            end
         end
         default: state_in = totp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= totp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      time_ff <= time_in;
      ctr_ff  <= ctr_in;
      left_ff <= left_in;
      ih_ff   <= ih_in;
      bin_ff  <= bin_in;
      otp_ff  <= otp_in;
   end

   assign req_tready = (state_ff == totp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, left_ff, otp_ff};

   // result stays below the modulus and the window count in range
   a_otp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> otp_ff < totp_pkg::pow10(digits_ff))
      else $error("code out of range");
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (left_ff != 9'd0 && left_ff <= period_ff))
      else $error("seconds left out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (sha_sts.busy || rsp_tvalid) |-> !req_tready)
      else $error("input taken while busy");

endmodule

[rtl/totp_sha1_core.sv]
// iterative sha-1 compression: one round per cycle on a shared round datapath
module totp_sha1_core (
   input  logic                  clock,
   input  logic                  reset,
   input  totp_pkg::sha_cmd_type cmd,
   input  logic [511:0]          block_data,
   output totp_pkg::sha_sts_type sts,
   output logic [159:0]          digest
);

   logic [159:0] h_ff, h_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [511:0] w_ff, w_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [31:0]  f, t, wt, wnew;
   logic [159:0] h_base;

   // round function and message schedule, word 0 sits in the top bits
   always_comb begin
      wt = w_ff[511:480];
      wnew = w_ff[95:64] ^ w_ff[255:224] ^ w_ff[447:416] ^ w_ff[511:480];
      wnew = {wnew[30:0], wnew[31]};
      if (rnd_ff < 7'd20)      f = (b_ff & c_ff) | (~b_ff & d_ff);
      else if (rnd_ff < 7'd40) f = b_ff ^ c_ff ^ d_ff;
      else if (rnd_ff < 7'd60) f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
      else                     f = b_ff ^ c_ff ^ d_ff;
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + totp_pkg::sha_k(rnd_ff) + wt;
   end

   // sequencing of 80 rounds and the final chaining add
   // a start held through the done cycle does not launch a second run
   always_comb begin
      h_base  = cmd.init ? totp_pkg::ShaInit : h_ff;
      h_in    = h_ff;
      a_in    = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      w_in    = w_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start && !busy_ff && !done_ff) begin
         h_in    = h_base;
         {a_in, b_in, c_in, d_in, e_in} = h_base;
         w_in    = block_data;
         rnd_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rnd_ff == 7'd80) begin
            h_in = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                    h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            e_in = d_ff;
            d_in = c_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            b_in = a_ff;
            a_in = t;
            w_in = {w_ff[479:0], wnew};
            rnd_in = rnd_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
      end
      h_ff <= h_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      w_ff <= w_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign digest   = h_ff;

endmodule

[rtl/totp_divider.sv]
// restoring divider, one quotient bit per cycle
module totp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] dividend,
   input  logic [26:0] divisor,
   output logic        done,
   output logic [62:0] quotient,
   output logic [26:0] remainder
);

   logic [62:0] q_ff, q_in;
   logic [26:0] r_ff, r_in;
   logic [26:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [27:0] trial;

   // shift in one dividend bit, compare and subtract
   // a start held through the done cycle does not launch a second run
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[62]};
      if (start && !busy_ff && !done_ff) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 6'd62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = 27'(trial - {1'b0, d_ff});
            q_in = {q_ff[61:0], 1'b1};
         end else begin
            r_in = trial[26:0];
            q_in = {q_ff[61:0], 1'b0};
         end
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule
